[rtl/ihsd_pkg.sv]
// Shared constants, state encoding and memory request types for the
// indirect descending heap sort core. No dependencies.
package ihsd_pkg;

   localparam int DEPTH         = 64;
   localparam int VALUE_BITS    = 32;
   localparam int IN_VALUE_BITS = 32;
   localparam int OUT_VALUE_BITS = 32;
   localparam int POS_BITS      = 6;
   localparam int IDX_BITS      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS      = $clog2(DEPTH + 1);
   localparam int NODE_BITS     = CNT_BITS + 1;
   localparam int RSP_DATA_BITS = ((POS_BITS + OUT_VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - POS_BITS - OUT_VALUE_BITS;

   typedef enum logic [4:0] {
      S_LOAD,
      S_INS_RD,
      S_INS_VAL,
      S_UP_CHK,
      S_UP_PH,
      S_UP_PV,
      S_EX_R0,
      S_EX_RE,
      S_EX_MV,
      S_EX_MVV,
      S_DN_CHK,
      S_DN_LH,
      S_DN_LV,
      S_DN_RV,
      S_DN_CMP,
      S_OUT_RH,
      S_OUT_RV,
      S_OUT_SET,
      S_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic                we;
      logic [IDX_BITS-1:0] waddr;
      logic [IDX_BITS-1:0] wdata;
      logic [IDX_BITS-1:0] raddr;
   } heap_req_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_BITS-1:0]   waddr;
      logic [VALUE_BITS-1:0] wdata;
      logic [IDX_BITS-1:0]   raddr;
   } val_req_type;

endpackage

[rtl/ihsd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module ihsd_ram #(
   parameter int WIDTH = 8,
   parameter int WORDS = 64
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(WORDS)-1:0]  waddr,
   input  logic [WIDTH-1:0]          wdata,
   input  logic [$clog2(WORDS)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/ihsd_ctrl.sv]
// Load, heap build, extraction and result sequencer for the sort core.
// Drives the value and position memories; depends on ihsd_pkg.
module ihsd_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ihsd_pkg::IN_VALUE_BITS-1:0]   req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ihsd_pkg::POS_BITS-1:0]        rsp_position,
   output logic [ihsd_pkg::OUT_VALUE_BITS-1:0]  rsp_value,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,
   output ihsd_pkg::heap_req_type               heap_req,
   input  logic [ihsd_pkg::IDX_BITS-1:0]        heap_rdata,
   output ihsd_pkg::val_req_type                val_req,
   input  logic [ihsd_pkg::VALUE_BITS-1:0]      val_rdata
);
   import ihsd_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic [CNT_BITS-1:0]   n_ff, n_in;
   logic [CNT_BITS-1:0]   i_ff, i_in;
   logic [CNT_BITS-1:0]   node_ff, node_in;
   logic [IDX_BITS-1:0]   mov_pos_ff, mov_pos_in;
   logic [VALUE_BITS-1:0] mov_val_ff, mov_val_in;
   logic [IDX_BITS-1:0]   root_pos_ff, root_pos_in;
   logic [IDX_BITS-1:0]   par_pos_ff, par_pos_in;
   logic [IDX_BITS-1:0]   lc_pos_ff, lc_pos_in;
   logic [VALUE_BITS-1:0] lc_val_ff, lc_val_in;
   logic [IDX_BITS-1:0]   rc_pos_ff, rc_pos_in;
   logic [IDX_BITS-1:0]   ch_pos_ff, ch_pos_in;
   logic [VALUE_BITS-1:0] ch_val_ff, ch_val_in;
   logic [CNT_BITS-1:0]   ch_idx_ff, ch_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [OUT_VALUE_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  req_acc;
   logic                  full;
   logic                  i_last;
   logic [CNT_BITS-1:0]   node_m1;
   logic [CNT_BITS-1:0]   par_idx;
   logic [NODE_BITS-1:0]  lc_idx;
   logic [NODE_BITS-1:0]  rc_idx;
   logic [NODE_BITS-1:0]  end_ext;
   logic                  lc_ok;
   logic                  rc_ok;
   state_type             ins_next;
   state_type             pass_next;

   assign req_acc = req_tvalid && (state_ff == S_LOAD);
   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign i_last  = ((i_ff + CNT_BITS'(1)) == n_ff);
   assign node_m1 = node_ff - CNT_BITS'(1);
   assign par_idx = node_m1 >> 1;
   assign lc_idx  = {node_ff, 1'b1};
   assign rc_idx  = {node_ff, 1'b0} + NODE_BITS'(2);
   assign end_ext = {1'b0, i_ff};
   assign lc_ok   = (lc_idx < end_ext);
   assign rc_ok   = (rc_idx < end_ext);

   always_comb begin
      if (!i_last) begin
         ins_next = S_INS_RD;
      end else if (n_ff == CNT_BITS'(1)) begin
         ins_next = S_OUT_RH;
      end else begin
         ins_next = S_EX_R0;
      end
      pass_next = (i_ff == CNT_BITS'(1)) ? S_OUT_RH : S_EX_R0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_acc && req_tlast) state_in = S_INS_RD;
         end
         S_INS_RD:  state_in = S_INS_VAL;
         S_INS_VAL: state_in = S_UP_CHK;
         S_UP_CHK: begin
            state_in = (node_ff == '0) ? ins_next : S_UP_PH;
         end
         S_UP_PH:   state_in = S_UP_PV;
         S_UP_PV: begin
            state_in = (val_rdata > mov_val_ff) ? S_UP_CHK : ins_next;
         end
         S_EX_R0:   state_in = S_EX_RE;
         S_EX_RE:   state_in = S_EX_MV;
         S_EX_MV:   state_in = S_EX_MVV;
         S_EX_MVV:  state_in = S_DN_CHK;
         S_DN_CHK:  state_in = lc_ok ? S_DN_LH : pass_next;
         S_DN_LH:   state_in = S_DN_LV;
         S_DN_LV:   state_in = rc_ok ? S_DN_RV : S_DN_CMP;
         S_DN_RV:   state_in = S_DN_CMP;
         S_DN_CMP: begin
            state_in = (mov_val_ff > ch_val_ff) ? S_DN_CHK : pass_next;
         end
         S_OUT_RH:  state_in = S_OUT_RV;
         S_OUT_RV:  state_in = S_OUT_SET;
         S_OUT_SET: state_in = S_OUT_WAIT;
         S_OUT_WAIT: begin
            if (rsp_tready) state_in = rsp_last_ff ? S_LOAD : S_OUT_RH;
         end
         default:   state_in = S_LOAD;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      node_in      = node_ff;
      mov_pos_in   = mov_pos_ff;
      mov_val_in   = mov_val_ff;
      root_pos_in  = root_pos_ff;
      par_pos_in   = par_pos_ff;
      lc_pos_in    = lc_pos_ff;
      lc_val_in    = lc_val_ff;
      rc_pos_in    = rc_pos_ff;
      ch_pos_in    = ch_pos_ff;
      ch_val_in    = ch_val_ff;
      ch_idx_in    = ch_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      heap_req     = '0;
      val_req      = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (!full) begin
                  val_req.we    = 1'b1;
                  val_req.waddr = count_ff[IDX_BITS-1:0];
                  val_req.wdata = VALUE_BITS'(req_tdata);
                  count_in      = count_ff + CNT_BITS'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  n_in = count_in;
                  i_in = '0;
               end
            end
         end
         S_INS_RD: begin
            val_req.raddr = i_ff[IDX_BITS-1:0];
            node_in       = i_ff;
            mov_pos_in    = i_ff[IDX_BITS-1:0];
         end
         S_INS_VAL: begin
            mov_val_in = val_rdata;
         end
         S_UP_CHK: begin
            if (node_ff == '0) begin
               heap_req.we    = 1'b1;
               heap_req.waddr = node_ff[IDX_BITS-1:0];
               heap_req.wdata = mov_pos_ff;
               if (!i_last) begin
                  i_in = i_ff + CNT_BITS'(1);
               end else if (n_ff == CNT_BITS'(1)) begin
                  i_in = '0;
               end
            end else begin
               heap_req.raddr = par_idx[IDX_BITS-1:0];
            end
         end
         S_UP_PH: begin
            par_pos_in    = heap_rdata;
            val_req.raddr = heap_rdata;
         end
         S_UP_PV: begin
            heap_req.we    = 1'b1;
            heap_req.waddr = node_ff[IDX_BITS-1:0];
            if (val_rdata > mov_val_ff) begin
               heap_req.wdata = par_pos_ff;
               node_in        = par_idx;
            end else begin
               heap_req.wdata = mov_pos_ff;
               if (!i_last) begin
                  i_in = i_ff + CNT_BITS'(1);
               end else if (n_ff == CNT_BITS'(1)) begin
                  i_in = '0;
               end
            end
         end
         S_EX_R0: begin
            heap_req.raddr = '0;
         end
         S_EX_RE: begin
            root_pos_in    = heap_rdata;
            heap_req.raddr = i_ff[IDX_BITS-1:0];
         end
         S_EX_MV: begin
            mov_pos_in     = heap_rdata;
            val_req.raddr  = heap_rdata;
            heap_req.we    = 1'b1;
            heap_req.waddr = i_ff[IDX_BITS-1:0];
            heap_req.wdata = root_pos_ff;
         end
         S_EX_MVV: begin
            mov_val_in = val_rdata;
            node_in    = '0;
         end
         S_DN_CHK: begin
            if (lc_ok) begin
               heap_req.raddr = lc_idx[IDX_BITS-1:0];
            end else begin
               heap_req.we    = 1'b1;
               heap_req.waddr = node_ff[IDX_BITS-1:0];
               heap_req.wdata = mov_pos_ff;
               i_in = (i_ff == CNT_BITS'(1)) ? '0 : i_ff - CNT_BITS'(1);
            end
         end
         S_DN_LH: begin
            lc_pos_in      = heap_rdata;
            val_req.raddr  = heap_rdata;
            heap_req.raddr = rc_idx[IDX_BITS-1:0];
         end
         S_DN_LV: begin
            if (rc_ok) begin
               rc_pos_in     = heap_rdata;
               val_req.raddr = heap_rdata;
               lc_val_in     = val_rdata;
            end else begin
               ch_pos_in = lc_pos_ff;
               ch_val_in = val_rdata;
               ch_idx_in = lc_idx[CNT_BITS-1:0];
            end
         end
         S_DN_RV: begin
            if (val_rdata < lc_val_ff) begin
               ch_pos_in = rc_pos_ff;
               ch_val_in = val_rdata;
               ch_idx_in = rc_idx[CNT_BITS-1:0];
            end else begin
               ch_pos_in = lc_pos_ff;
               ch_val_in = lc_val_ff;
               ch_idx_in = lc_idx[CNT_BITS-1:0];
            end
         end
         S_DN_CMP: begin
            heap_req.we    = 1'b1;
            heap_req.waddr = node_ff[IDX_BITS-1:0];
            if (mov_val_ff > ch_val_ff) begin
               heap_req.wdata = ch_pos_ff;
               node_in        = ch_idx_ff;
            end else begin
               heap_req.wdata = mov_pos_ff;
               i_in = (i_ff == CNT_BITS'(1)) ? '0 : i_ff - CNT_BITS'(1);
            end
         end
         S_OUT_RH: begin
            heap_req.raddr = i_ff[IDX_BITS-1:0];
         end
         S_OUT_RV: begin
            mov_pos_in    = heap_rdata;
            val_req.raddr = heap_rdata;
         end
         S_OUT_SET: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = POS_BITS'(mov_pos_ff);
            rsp_val_in   = OUT_VALUE_BITS'(val_rdata);
            rsp_last_in  = i_last;
            rsp_ovf_in   = drop_ff;
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
               end else begin
                  i_in = i_ff + CNT_BITS'(1);
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      node_ff     <= node_in;
      mov_pos_ff  <= mov_pos_in;
      mov_val_ff  <= mov_val_in;
      root_pos_ff <= root_pos_in;
      par_pos_ff  <= par_pos_in;
      lc_pos_ff   <= lc_pos_in;
      lc_val_ff   <= lc_val_in;
      rc_pos_ff   <= rc_pos_in;
      ch_pos_ff   <= ch_pos_in;
      ch_val_ff   <= ch_val_in;
      ch_idx_ff   <= ch_idx_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_tready   = (state_ff == S_LOAD);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_value    = rsp_val_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser    = rsp_ovf_ff;

endmodule

[rtl/indirect_heap_sort_descending_core.sv]
// Top level of the indirect descending heap sort core: sequencer plus the
// value and position memories. Depends on ihsd_pkg, ihsd_ram and ihsd_ctrl.
//
// Values load one item per cycle into a value memory, up to DEPTH of them;
// further items are dropped and flag overflow on every result of that run.
// The item with tlast closes the set: the block then stops accepting items,
// builds a min-heap of load positions by sift-up insertion, extracts it in
// place, and streams one result per stored value in descending value order
// (ties fall as the heap leaves them), tlast on the final one. Each memory
// has one read port with registered read data and every heap step waits on
// it: an insertion sifts the new position up one parent compare at a time,
// an extraction pass sifts the moved position down one child compare at a
// time (reading the right child too when one exists), and each result waits
// for rsp_tready.
module indirect_heap_sort_descending_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [ihsd_pkg::IN_VALUE_BITS-1:0] req_tdata, // value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [ihsd_pkg::RSP_DATA_BITS-1:0] rsp_tdata, // position, sorted_value, zero pad
   output logic        rsp_tlast,
   output logic        rsp_tuser  // overflow
);
   import ihsd_pkg::*;

   heap_req_type          heap_req;
   val_req_type           val_req;
   logic [IDX_BITS-1:0]   heap_rdata;
   logic [VALUE_BITS-1:0] val_rdata;
   logic [POS_BITS-1:0]   rsp_position;
   logic [OUT_VALUE_BITS-1:0] rsp_value;

   ihsd_ram #(
      .WIDTH (VALUE_BITS),
      .WORDS (DEPTH)
   ) u_value_ram (
      .clock (clock),
      .we    (val_req.we),
      .waddr (val_req.waddr),
      .wdata (val_req.wdata),
      .raddr (val_req.raddr),
      .rdata (val_rdata)
   );

   ihsd_ram #(
      .WIDTH (IDX_BITS),
      .WORDS (DEPTH)
   ) u_heap_ram (
      .clock (clock),
      .we    (heap_req.we),
      .waddr (heap_req.waddr),
      .wdata (heap_req.wdata),
      .raddr (heap_req.raddr),
      .rdata (heap_rdata)
   );

   ihsd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_position (rsp_position),
      .rsp_value    (rsp_value),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .heap_req     (heap_req),
      .heap_rdata   (heap_rdata),
      .val_req      (val_req),
      .val_rdata    (val_rdata)
   );

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, rsp_value, rsp_position};

   a_no_load_while_output : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input ready while a result is pending");

   a_closing_item_stops_load : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready && !rsp_tvalid)
      else $error("load continued after closing item");

   a_final_result_reopens : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block not ready after final result");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for indirect_heap_sort_descending_core: streams sets of values and checks
// every result against an in-bench heap sort of the load positions, or against the stated result for typed items.
// Depends on ihsd_pkg and the core RTL.
module tb;
   import ihsd_pkg::*;

   localparam int IDLE_LIMIT   = 20000;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 420;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [POS_BITS-1:0]       pos;
      logic [OUT_VALUE_BITS-1:0] val;
      logic                      fin;
      logic                      ovf;
   } result_t;

   typedef struct packed {
      logic [IN_VALUE_BITS-1:0] value;
      logic                     last;
      logic                     typed;
      result_t                  want;
   } feed_t;

   localparam feed_t DIRECTED [24] = '{
      '{32'h0000_0000, 1'b1, 1'b1, '{6'd0, 32'h0000_0000, 1'b1, 1'b0}},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, '{6'd0, 32'hFFFF_FFFF, 1'b1, 1'b0}},
      '{32'd5, 1'b0, 1'b0, '0},
      '{32'd5, 1'b1, 1'b0, '0},
      '{32'h0000_0001, 1'b0, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 1'b0, 1'b0, '0},
      '{32'h8000_0000, 1'b0, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
      '{32'd3, 1'b0, 1'b0, '0},
      '{32'd2, 1'b0, 1'b0, '0},
      '{32'd1, 1'b1, 1'b0, '0},
      '{32'd9, 1'b0, 1'b0, '0},
      '{32'd4, 1'b0, 1'b0, '0},
      '{32'd4, 1'b0, 1'b0, '0},
      '{32'd4, 1'b0, 1'b0, '0},
      '{32'd4, 1'b1, 1'b0, '0},
      '{32'd0, 1'b0, 1'b0, '0},
      '{32'd1, 1'b0, 1'b0, '0},
      '{32'd2, 1'b0, 1'b0, '0},
      '{32'd3, 1'b0, 1'b0, '0},
      '{32'd4, 1'b0, 1'b0, '0},
      '{32'd5, 1'b0, 1'b0, '0},
      '{32'd6, 1'b1, 1'b0, '0}
   };

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [IN_VALUE_BITS-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;

   logic [VALUE_BITS-1:0] held_vals [DEPTH];
   int                    heap_pos  [DEPTH];
   int                    held_count   = 0;
   bit                    held_dropped = 1'b0;

   feed_t   feed_q[$];
   result_t sorted_q[$];
   int      fed    = 0;
   int      errors = 0;
   int      idle_cycles = 0;

   indirect_heap_sort_descending_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Store one value; on last, sort the positions and queue the expected results.
   task automatic load_and_sort(input feed_t f);
      int n, i, node, par, pp, np, e, moving, lc, rc, ch, cp;
      result_t r;
      if (held_count < DEPTH) begin
         held_vals[held_count] = f.value[VALUE_BITS-1:0];
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (f.last) begin
         n = held_count;
         for (i = 0; i < n; i++) begin
            node = i;
            heap_pos[i] = i;
            while (node > 0) begin
               par = (node - 1) / 2;
               pp  = heap_pos[par];
               np  = heap_pos[node];
               if (held_vals[pp] > held_vals[np]) begin
                  heap_pos[par]  = np;
                  heap_pos[node] = pp;
                  node = par;
               end else begin
                  break;
               end
            end
         end
         for (i = n; i > 0; i--) begin
            e = i - 1;
            node = 0;
            moving = heap_pos[e];
            heap_pos[e] = heap_pos[0];
            heap_pos[0] = moving;
            forever begin
               lc = 2 * node + 1;
               rc = lc + 1;
               if (lc >= e) break;
               ch = lc;
               if (rc < e && held_vals[heap_pos[rc]] < held_vals[heap_pos[lc]]) ch = rc;
               cp = heap_pos[ch];
               if (held_vals[moving] > held_vals[cp]) begin
                  heap_pos[ch]   = moving;
                  heap_pos[node] = cp;
                  node = ch;
               end else begin
                  break;
               end
            end
         end
         if (f.typed) begin
            sorted_q.push_back(f.want);
         end else begin
            for (i = 0; i < n; i++) begin
               r.pos = heap_pos[i][POS_BITS-1:0];
               r.val = held_vals[heap_pos[i]];
               r.fin = (i == n - 1);
               r.ovf = held_dropped;
               sorted_q.push_back(r);
            end
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      result_t got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            load_and_sort(feed_q[fed]);
            fed++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pos = rsp_tdata[POS_BITS-1:0];
            got.val = rsp_tdata[POS_BITS +: OUT_VALUE_BITS];
            got.fin = rsp_tlast;
            got.ovf = rsp_tuser;
            if (sorted_q.size() == 0) begin
               $display("%0t: unexpected result pos %0d value %h last %b overflow %b",
                        $time, got.pos, got.val, got.fin, got.ovf);
               errors++;
            end else begin
               want = sorted_q.pop_front();
               if (got.pos !== want.pos || got.val !== want.val ||
                   got.fin !== want.fin || got.ovf !== want.ovf) begin
                  $display("%0t: expected pos %0d value %h last %b overflow %b, got pos %0d value %h last %b overflow %b",
                           $time, want.pos, want.val, want.fin, want.ovf,
                           got.pos, got.val, got.fin, got.ovf);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Sender: bursts of random length, random gaps between them.
   initial begin : sender
      int burst_left, gap_left, sent;
      bit took;
      burst_left = 0;
      gap_left   = 0;
      sent       = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         took = req_tvalid && req_tready;
         if (took) begin
            sent++;
            if (burst_left > 0) burst_left--;
         end
         if (sent == feed_q.size()) begin
            req_tvalid <= 1'b0;
            break;
         end
         if (!req_tvalid || took) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 2);
                  2: gap_left = $urandom_range(1, 6);
                  default: gap_left = $urandom_range(8, 30);
               endcase
            end
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= feed_q[sent].value;
               req_tlast  <= feed_q[sent].last;
            end
         end
         @(posedge clock);
      end
   end

   // Receiver: stall pattern of its own, plus long hold-offs to back up the input.
   initial begin : receiver
      int hold_left, seen, phase, mode;
      hold_left = 0;
      seen      = 0;
      phase     = 0;
      mode      = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            seen++;
            if (seen == 40 || seen == 300) hold_left = LONG_HOLD;
         end
         phase++;
         if (phase % 97 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (phase % 4 != 0);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : main
      int set_idx, set_size, i, total, mode;
      logic [IN_VALUE_BITS-1:0] v;
      feed_t f;
      foreach (DIRECTED[r]) feed_q.push_back(DIRECTED[r]);
      total   = 0;
      set_idx = 0;
      while (total < RANDOM_ITEMS) begin
         if (set_idx == 2) set_size = DEPTH;
         else if (set_idx == 7) set_size = DEPTH + 1;
         else if (set_idx == 12) set_size = DEPTH + 6;
         else if ($urandom_range(0, 4) == 0) set_size = $urandom_range(13, 40);
         else set_size = $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         for (i = 0; i < set_size; i++) begin
            case (mode)
               0: v = $urandom();
               1: v = $urandom_range(0, 3);
               default: begin
                  case ($urandom_range(0, 3))
                     0: v = '0;
                     1: v = '1;
                     2: v = $urandom_range(0, 15);
                     default: v = $urandom();
                  endcase
               end
            endcase
            f.value = v;
            f.last  = (i == set_size - 1);
            f.typed = 1'b0;
            f.want  = '0;
            feed_q.push_back(f);
         end
         total += set_size;
         set_idx++;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (!(fed == feed_q.size() && sorted_q.size() == 0)) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
rtl/ihsd_pkg.sv
rtl/ihsd_ram.sv
rtl/ihsd_ctrl.sv
rtl/indirect_heap_sort_descending_core.sv
verif/tb.sv
